// File: hw/rtl/two_axis_line_step_planner_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-axis line step planner
// Shared clocking and reset handling for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef TWO_AXIS_LINE_STEP_PLANNER_ASSERT_SVH
`define TWO_AXIS_LINE_STEP_PLANNER_ASSERT_SVH

// A property checked at every rising clock edge outside reset.
`define TLSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// A condition that must never be true outside reset.
`define TLSP_NEVER(lbl, cond, msg) \
  `TLSP_ASSERT(lbl, !(cond), msg)

`endif

// File: hw/rtl/tlsp_pkg.sv
// ----------------------------------------------------------------------------
// Two-axis line step planner package
// Widths, constants, register codes and the records handed along the cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlsp_pkg;

  // Positions and their difference.
  localparam int POS_W   = 24;
  localparam int DIFF_W  = POS_W + 1;
  localparam int MAG_W   = POS_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;

  // Step count: the step size register has 8 fractional bits.
  localparam int STEP_FRAC = 8;
  localparam int STEP_Q_W  = MAG_W + STEP_FRAC;
  localparam int STEP_W    = 33;
  localparam int SIZE_W    = 16;
  localparam int CFG_W     = 16;

  // Root chain: one root bit per cell, radicand padded to an even shift.
  localparam int PLAN_CELLS = STEP_Q_W;
  localparam int RAD_W      = 2 * PLAN_CELLS;
  localparam int RAD_PAD    = RAD_W - SUM_W;
  localparam int ROOT_W     = PLAN_CELLS;
  localparam int ROOT_FRAC  = RAD_PAD / 2;
  localparam int LEN_W      = ROOT_W - ROOT_FRAC;
  localparam int ROOT_REM_W = ROOT_W + 2;

  // Delay division.
  localparam int SPEED_W     = 24;
  localparam int US_W        = 20;
  localparam int NUM_W       = LEN_W + US_W;
  localparam int DEN_W       = SPEED_W + STEP_Q_W;
  localparam int DELAY_W     = 32;
  localparam int DELAY_CELLS = NUM_W;

  localparam logic [US_W-1:0]    US_PER_S      = 20'd1000000;
  // 7.5 mm/s expressed in micrometres per second.
  localparam logic [SPEED_W-1:0] DEFAULT_SPEED = 24'd7500;
  localparam logic [SIZE_W-1:0]  STEP_SIZE_RST = 16'd256;
  localparam logic [CFG_W-1:0]   MIN_DELAY_RST = 16'd0;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_SIZE1 = 2'd0,
    REG_STEP_SIZE2 = 2'd1,
    REG_MIN_DELAY1 = 2'd2,
    REG_MIN_DELAY2 = 2'd3
  } cfg_reg_e;

  // Record handed along the root and step division cells.
  typedef struct packed {
    logic                            vld;
    logic [SPEED_W-1:0]              spd;
    logic [1:0]                      neg;
    logic [RAD_W-1:0]                rad;
    logic [ROOT_W-1:0]               root;
    logic [ROOT_REM_W-1:0]           rrem;
    logic [1:0][STEP_Q_W-1:0]        dvd;
    logic [1:0][SIZE_W-1:0]          srem;
  } plan_t;

  // Record handed along the delay division cells.
  typedef struct packed {
    logic                            vld;
    logic [1:0]                      neg;
    logic [1:0][STEP_Q_W-1:0]        mag;
    logic [1:0][DEN_W-1:0]           den;
    logic [1:0][NUM_W-1:0]           dvd;
    logic [1:0][DEN_W-1:0]           rem;
  } delay_t;

  typedef struct packed {
    logic [1:0][STEP_W-1:0]          steps;
    logic [1:0][DELAY_W-1:0]         delay;
  } result_t;

endpackage

// File: hw/rtl/tlsp_if.sv
// ----------------------------------------------------------------------------
// Two-axis line step planner channels
// Valid/ready channels for move items in and planned items out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tlsp_in_if import tlsp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [POS_W-1:0]   target_axis1;
  logic signed [POS_W-1:0]   target_axis2;
  logic signed [POS_W-1:0]   current_pos_axis1;
  logic signed [POS_W-1:0]   current_pos_axis2;
  logic        [SPEED_W-1:0] speed;

  modport source (
    output valid, target_axis1, target_axis2, current_pos_axis1,
           current_pos_axis2, speed,
    input  ready
  );
  modport sink (
    input  valid, target_axis1, target_axis2, current_pos_axis1,
           current_pos_axis2, speed,
    output ready
  );
endinterface

interface tlsp_out_if import tlsp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [STEP_W-1:0]  steps_axis1;
  logic signed [STEP_W-1:0]  steps_axis2;
  logic        [DELAY_W-1:0] delay_axis1;
  logic        [DELAY_W-1:0] delay_axis2;

  modport source (
    output valid, steps_axis1, steps_axis2, delay_axis1, delay_axis2,
    input  ready
  );
  modport sink (
    input  valid, steps_axis1, steps_axis2, delay_axis1, delay_axis2,
    output ready
  );
endinterface

// File: hw/rtl/tlsp_plan_cell.sv
// ----------------------------------------------------------------------------
// Planner cell
// One root digit of the path length and one step count quotient bit per axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlsp_plan_cell import tlsp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [1:0][SIZE_W-1:0] size_i,
  input  plan_t                  cell_i,
  output plan_t                  cell_o
);

  plan_t cell_d;
  plan_t cell_q;

  always_comb begin
    logic [ROOT_REM_W+1:0] rt;
    logic [ROOT_REM_W+1:0] trial;
    logic                  rge;
    logic [SIZE_W:0]       st;
    logic                  sge;
    cell_d = cell_i;
    // Root digit: bring down two radicand bits and try the next root bit.
    rt    = {cell_i.rrem, cell_i.rad[RAD_W-1 -: 2]};
    trial = (ROOT_REM_W + 2)'({cell_i.root, 2'b01});
    rge   = (rt >= trial);
    cell_d.rrem = rge ? ROOT_REM_W'(rt - trial) : ROOT_REM_W'(rt);
    cell_d.root = {cell_i.root[ROOT_W-2:0], rge};
    cell_d.rad  = {cell_i.rad[RAD_W-3:0], 2'b00};
    // Restoring division step; quotient bits shift into the dividend.
    for (int k = 0; k < 2; k++) begin
      st  = {cell_i.srem[k], cell_i.dvd[k][STEP_Q_W-1]};
      sge = (st >= {1'b0, size_i[k]});
      cell_d.srem[k] = sge ? SIZE_W'(st - {1'b0, size_i[k]}) : SIZE_W'(st);
      cell_d.dvd[k]  = {cell_i.dvd[k][STEP_Q_W-2:0], sge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q.vld <= 1'b0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// File: hw/rtl/tlsp_delay_cell.sv
// ----------------------------------------------------------------------------
// Delay cell
// One quotient bit of the step delay division for each axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlsp_delay_cell import tlsp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  delay_t cell_i,
  output delay_t cell_o
);

  delay_t cell_d;
  delay_t cell_q;

  always_comb begin
    logic [DEN_W:0] t;
    logic           ge;
    cell_d = cell_i;
    for (int k = 0; k < 2; k++) begin
      t  = {cell_i.rem[k], cell_i.dvd[k][NUM_W-1]};
      ge = (t >= {1'b0, cell_i.den[k]});
      cell_d.rem[k] = ge ? DEN_W'(t - {1'b0, cell_i.den[k]}) : DEN_W'(t);
      cell_d.dvd[k] = {cell_i.dvd[k][NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q.vld <= 1'b0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// File: hw/rtl/tlsp_out_buf.sv
// ----------------------------------------------------------------------------
// Output buffer
// Two-entry queue that decouples the planner chain from the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "two_axis_line_step_planner_assert.svh"

module tlsp_out_buf import tlsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  result_t    data_i,
  output logic       room_o,
  tlsp_out_if.source out_o
);

  localparam logic [1:0] BUF_FULL = 2'd2;
  localparam logic [1:0] BUF_ONE  = 2'd1;

  result_t    ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop    = out_o.valid && out_o.ready;
  assign room_o = (cnt_q != BUF_FULL);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= data_i;
    end
  end

  assign out_o.valid       = (cnt_q != 2'd0);
  assign out_o.steps_axis1 = $signed(ent_q[rd_ptr_q].steps[0]);
  assign out_o.steps_axis2 = $signed(ent_q[rd_ptr_q].steps[1]);
  assign out_o.delay_axis1 = ent_q[rd_ptr_q].delay[0];
  assign out_o.delay_axis2 = ent_q[rd_ptr_q].delay[1];

  `TLSP_NEVER(a_buf_overrun, push_i && (cnt_q == BUF_FULL), "item pushed into full buffer")
  `TLSP_ASSERT(a_cnt_hold, (push_i == pop) |=> $stable(cnt_q), "fill count moved unbalanced")
  `TLSP_ASSERT(a_drain, (pop && !push_i && (cnt_q == BUF_ONE)) |=> !out_o.valid, "valid after last item left")

endmodule

// File: hw/rtl/two_axis_line_step_planner.sv
// ----------------------------------------------------------------------------
// Two-axis line step planner
// Turns a straight two-axis move into signed step counts and step delays.
// ----------------------------------------------------------------------------
// Move items arrive on in_i (targets, present positions and path speed) and
// planned items leave on out_o (signed step counts and per-axis delays in
// microseconds). Both channels move an item at a clock edge where valid and
// ready are high. The four configuration registers are written through
// cfg_we_i, cfg_idx_i and cfg_data_i, and should only change while no item
// is in flight.
// The block takes one item in every cycle while the output buffer has room.
// An accepted item passes three entry stages, 32 planner cells that each
// produce one root bit and one step count bit, a multiplier stage and 45
// delay cells that each produce one quotient bit, then the output buffer.
// The whole chain advances together. A two-entry output buffer sits at the
// end, so in_i.ready depends only on the fill of that buffer and never on
// out_o.ready directly. When the receiver stalls, the buffer fills and the
// chain freezes with every item held in place; nothing is lost.
// Reset clears every valid bit and loads the step sizes with 256 (one
// micrometre per step) and the minimum delays with zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "two_axis_line_step_planner_assert.svh"

module two_axis_line_step_planner import tlsp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  tlsp_in_if.sink              in_i,
  tlsp_out_if.source           out_o
);

  typedef struct packed {
    logic                   vld;
    logic [1:0][MAG_W-1:0]  mag;
    logic [1:0]             neg;
    logic [SPEED_W-1:0]     spd;
  } ent_t;

  typedef struct packed {
    logic                   vld;
    logic [1:0][SQ_W-1:0]   sq;
    logic [1:0][MAG_W-1:0]  mag;
    logic [1:0]             neg;
    logic [SPEED_W-1:0]     spd;
  } sq_t;

  typedef struct packed {
    logic                   vld;
    logic [SUM_W-1:0]       sum;
    logic [1:0][MAG_W-1:0]  mag;
    logic [1:0]             neg;
    logic [SPEED_W-1:0]     spd;
  } sum_t;

  // Configuration registers.
  logic [1:0][SIZE_W-1:0] step_size_q;
  logic [1:0][CFG_W-1:0]  min_delay_q;
  logic [1:0][SIZE_W-1:0] size_eff;

  // The chain moves only when the output buffer has room.
  logic    en;
  logic    push;
  result_t res;

  ent_t s0_q, s0_d;
  sq_t  s1_q, s1_d;
  sum_t s2_q, s2_d;

  plan_t  plan_c [PLAN_CELLS+1];
  delay_t m_d, m_q;
  delay_t del_c  [DELAY_CELLS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_size_q <= {STEP_SIZE_RST, STEP_SIZE_RST};
      min_delay_q <= {MIN_DELAY_RST, MIN_DELAY_RST};
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_STEP_SIZE1: step_size_q[0] <= cfg_data_i;
        REG_STEP_SIZE2: step_size_q[1] <= cfg_data_i;
        REG_MIN_DELAY1: min_delay_q[0] <= cfg_data_i;
        REG_MIN_DELAY2: min_delay_q[1] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A step size of zero behaves as the smallest step.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      size_eff[k] = (step_size_q[k] == '0) ? SIZE_W'(1) : step_size_q[k];
    end
  end

  assign in_i.ready = en;

  // Entry stage: displacement magnitude, direction and effective speed.
  always_comb begin
    logic signed [DIFF_W-1:0] d1;
    logic signed [DIFF_W-1:0] d2;
    d1 = DIFF_W'(in_i.target_axis1) - DIFF_W'(in_i.current_pos_axis1);
    d2 = DIFF_W'(in_i.target_axis2) - DIFF_W'(in_i.current_pos_axis2);
    s0_d.vld    = in_i.valid;
    s0_d.neg[0] = d1[DIFF_W-1];
    s0_d.neg[1] = d2[DIFF_W-1];
    s0_d.mag[0] = d1[DIFF_W-1] ? MAG_W'(-d1) : MAG_W'(d1);
    s0_d.mag[1] = d2[DIFF_W-1] ? MAG_W'(-d2) : MAG_W'(d2);
    s0_d.spd    = (in_i.speed == '0) ? DEFAULT_SPEED : in_i.speed;
  end

  always_comb begin
    s1_d.vld   = s0_q.vld;
    s1_d.mag   = s0_q.mag;
    s1_d.neg   = s0_q.neg;
    s1_d.spd   = s0_q.spd;
    s1_d.sq[0] = SQ_W'(s0_q.mag[0]) * SQ_W'(s0_q.mag[0]);
    s1_d.sq[1] = SQ_W'(s0_q.mag[1]) * SQ_W'(s0_q.mag[1]);
  end

  always_comb begin
    s2_d.vld = s1_q.vld;
    s2_d.mag = s1_q.mag;
    s2_d.neg = s1_q.neg;
    s2_d.spd = s1_q.spd;
    s2_d.sum = SUM_W'(s1_q.sq[0]) + SUM_W'(s1_q.sq[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q.vld <= 1'b0;
      s1_q.vld <= 1'b0;
      s2_q.vld <= 1'b0;
    end else if (en) begin
      s0_q <= s0_d;
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

  // The radicand is scaled by an even power of two so that the root chain
  // runs as many digits as the step division has quotient bits; the extra
  // fractional root bits are dropped after the last cell.
  always_comb begin
    plan_c[0].vld  = s2_q.vld;
    plan_c[0].spd  = s2_q.spd;
    plan_c[0].neg  = s2_q.neg;
    plan_c[0].rad  = {s2_q.sum, RAD_PAD'(0)};
    plan_c[0].root = '0;
    plan_c[0].rrem = '0;
    for (int k = 0; k < 2; k++) begin
      plan_c[0].dvd[k]  = {s2_q.mag[k], STEP_FRAC'(0)};
      plan_c[0].srem[k] = '0;
    end
  end

  for (genvar i = 0; i < PLAN_CELLS; i++) begin : g_plan
    tlsp_plan_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .size_i (size_eff),
      .cell_i (plan_c[i]),
      .cell_o (plan_c[i+1])
    );
  end

  // Multiplier stage: length times one million over speed times steps.
  // With 24-bit positions the step count stays below 2^32, so it needs no
  // clamping before it is used.
  always_comb begin
    logic [LEN_W-1:0] len;
    logic [NUM_W-1:0] num;
    len     = plan_c[PLAN_CELLS].root[ROOT_W-1:ROOT_FRAC];
    num     = NUM_W'(len) * NUM_W'(US_PER_S);
    m_d.vld = plan_c[PLAN_CELLS].vld;
    m_d.neg = plan_c[PLAN_CELLS].neg;
    for (int k = 0; k < 2; k++) begin
      m_d.mag[k] = plan_c[PLAN_CELLS].dvd[k];
      m_d.den[k] = DEN_W'(plan_c[PLAN_CELLS].spd) * DEN_W'(plan_c[PLAN_CELLS].dvd[k]);
      m_d.dvd[k] = num;
      m_d.rem[k] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q.vld <= 1'b0;
    end else if (en) begin
      m_q <= m_d;
    end
  end

  assign del_c[0] = m_q;

  for (genvar i = 0; i < DELAY_CELLS; i++) begin : g_delay
    tlsp_delay_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (del_c[i]),
      .cell_o (del_c[i+1])
    );
  end

  // Final shaping: sign the step counts, clamp the quotient, drop delays under
  // the axis minimum, and give an axis without steps a delay of zero.
  always_comb begin
    logic [NUM_W-1:0]    q;
    logic [DELAY_W-1:0]  sat;
    logic [STEP_W-1:0]   mag;
    for (int k = 0; k < 2; k++) begin
      q   = del_c[DELAY_CELLS].dvd[k];
      sat = (|q[NUM_W-1:DELAY_W]) ? '1 : q[DELAY_W-1:0];
      mag = STEP_W'(del_c[DELAY_CELLS].mag[k]);
      res.steps[k] = del_c[DELAY_CELLS].neg[k] ? (STEP_W'(0) - mag) : mag;
      if ((del_c[DELAY_CELLS].mag[k] == '0) || (sat < DELAY_W'(min_delay_q[k]))) begin
        res.delay[k] = '0;
      end else begin
        res.delay[k] = sat;
      end
    end
  end

  assign push = en && del_c[DELAY_CELLS].vld;

  tlsp_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (res),
    .room_o (en),
    .out_o  (out_o)
  );

  `TLSP_ASSERT(a_acc_capt, (in_i.valid && in_i.ready) |=> s0_q.vld, "accepted item not captured")
  `TLSP_ASSERT(a_freeze, !en |=> $stable(m_q.vld), "chain moved while stalled")
  `TLSP_ASSERT(a_zero_delay, (out_o.valid && (out_o.steps_axis1 == '0)) |-> (out_o.delay_axis1 == '0), "delay without steps")

endmodule
